// ----- rtl/cfm_pkg.sv -----
// ----------------------------------------------------------------------------
// Crossing frequency meter package
// Shared widths, codes, the seven-segment decoder and the job word that the
// front part hands to the back part.
// ----------------------------------------------------------------------------
package cfm_pkg;

   localparam int SAMPLE_BITS    = 12;
   localparam int MAX_DIGITS     = 7;
   localparam int COUNT_BITS     = 8;
   localparam int TIME_BITS      = 32;
   localparam int FREQ_BITS      = 24;
   localparam int SEG_BITS       = 8;
   localparam int KIND_BITS      = 2;
   localparam int DIGIT_BITS     = 4;

   localparam int CSR_ADDR_BITS  = 3;
   localparam int CSR_DATA_BITS  = 32;

   // Register select is address bit 2 (one register every four bytes).
   localparam logic CSR_THRESHOLD = 1'b0;
   localparam logic CSR_CROSSINGS = 1'b1;

   localparam logic [SAMPLE_BITS-1:0] THRESHOLD_RESET = SAMPLE_BITS'(819);
   localparam logic [COUNT_BITS-1:0]  CROSSINGS_RESET = COUNT_BITS'(10);
   localparam logic [COUNT_BITS-1:0]  MIN_CROSSINGS   = COUNT_BITS'(2);

   localparam logic [KIND_BITS-1:0] KIND_DIGIT  = 2'd0;
   localparam logic [KIND_BITS-1:0] KIND_BLANK  = 2'd1;
   localparam logic [KIND_BITS-1:0] KIND_REPORT = 2'd2;

   // Divider sizing: periods (8 bits) times one million (20 bits) gives the
   // numerator; the rounded dividend is twice that plus the elapsed time.
   localparam int US_BITS   = 20;
   localparam logic [US_BITS-1:0] US_PER_S = US_BITS'(1000000);
   localparam int PROD_BITS = COUNT_BITS + US_BITS;
   localparam int DVD_BITS  = TIME_BITS + 1;
   localparam int QUO_BITS  = PROD_BITS;
   localparam int STEP_BITS = $clog2(QUO_BITS);

   // Divide by ten through a reciprocal, exact for any 24-bit value.
   localparam logic [FREQ_BITS-1:0] RECIP_TEN   = 24'hCCCCCD;
   localparam int                   RECIP_SHIFT = 27;

   localparam int DIGIT_CNT_BITS = $clog2(MAX_DIGITS + 1);
   localparam int DIGIT_IDX_BITS = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

   localparam logic [SEG_BITS-1:0] SEG_DOT = 8'h80;

   localparam int JOB_DEPTH    = 2;
   localparam int JOB_PTR_BITS = 1;
   localparam int JOB_CNT_BITS = 2;

   function automatic longint cap_calc();
      longint p;
      p = 1;
      for (int i = 0; i < MAX_DIGITS; i++) begin
         p = p * 10;
      end
      p = p - 1;
      return (p > 64'd9999999) ? 64'd9999999 : p;
   endfunction

   localparam logic [FREQ_BITS-1:0] FREQ_CAP = FREQ_BITS'(cap_calc());

   typedef struct packed {
      logic [COUNT_BITS-1:0] periods;
      logic [TIME_BITS-1:0]  elapsed;
      logic                  mode;
   } job_type;

   function automatic logic [SEG_BITS-1:0] seg_decode(input logic [DIGIT_BITS-1:0] d);
      logic [SEG_BITS-1:0] s;
      unique case (d)
         4'd0:    s = 8'h3F;
         4'd1:    s = 8'h06;
         4'd2:    s = 8'h5B;
         4'd3:    s = 8'h4F;
         4'd4:    s = 8'h66;
         4'd5:    s = 8'h6D;
         4'd6:    s = 8'h7D;
         4'd7:    s = 8'h07;
         4'd8:    s = 8'h7F;
         4'd9:    s = 8'h6F;
         default: s = 8'h00;
      endcase
      return s;
   endfunction

endpackage

// ----- rtl/cfm_front.sv -----
// ----------------------------------------------------------------------------
// Crossing frequency meter front end
// Detects rising threshold crossings, counts them and emits one job word per
// completed measurement.
// ----------------------------------------------------------------------------
module cfm_front
   import cfm_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic [SAMPLE_BITS-1:0] threshold,
   input  logic [COUNT_BITS-1:0]  crossings,
   input  logic                   item_accept,
   input  logic [SAMPLE_BITS-1:0] sample,
   input  logic [TIME_BITS-1:0]   now_us,
   input  logic                   mode_switch,
   output logic                   job_push,
   output job_type                job
);

   logic [SAMPLE_BITS-1:0] prev_ff, prev_in;
   logic [COUNT_BITS-1:0]  count_ff, count_in;
   logic [TIME_BITS-1:0]   start_ff, start_in;

   logic                   crossing;
   logic                   complete;
   logic [COUNT_BITS-1:0]  count_step;
   logic [COUNT_BITS-1:0]  target;
   logic [TIME_BITS-1:0]   start_now;

   assign crossing   = (prev_ff < threshold) && (sample >= threshold);
   assign count_step = COUNT_BITS'(count_ff + 1'b1);
   assign target     = (crossings < MIN_CROSSINGS) ? MIN_CROSSINGS : crossings;
   assign start_now  = (count_ff == '0) ? now_us : start_ff;
   assign complete   = crossing && (count_step >= target);

   always_comb begin
      prev_in  = prev_ff;
      count_in = count_ff;
      start_in = start_ff;
      if (item_accept) begin
         prev_in = sample;
         if (crossing) begin
            start_in = start_now;
            count_in = complete ? '0 : count_step;
         end
      end
   end

   assign job_push    = item_accept && complete;
   assign job.periods = COUNT_BITS'(count_step - 1'b1);
   assign job.elapsed = TIME_BITS'(now_us - start_now);
   assign job.mode    = mode_switch;

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff  <= '0;
         count_ff <= '0;
         start_ff <= '0;
      end else begin
         prev_ff  <= prev_in;
         count_ff <= count_in;
         start_ff <= start_in;
      end
   end

endmodule

// ----- rtl/cfm_queue.sv -----
// ----------------------------------------------------------------------------
// Crossing frequency meter job queue
// Two-entry queue of job words between the front end and the back end.
// ----------------------------------------------------------------------------
module cfm_queue
   import cfm_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    full,
   input  logic    pop,
   output job_type pop_job,
   output logic    empty
);

   job_type                   entry_ff [JOB_DEPTH];
   logic [JOB_PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [JOB_PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [JOB_CNT_BITS-1:0]   count_ff, count_in;
   logic                      do_push;
   logic                      do_pop;

   assign full    = (count_ff == JOB_CNT_BITS'(JOB_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign pop_job = entry_ff[rd_ptr_ff];

   // The depth is a power of two, so the pointers wrap on their own.
   always_comb begin
      wr_ptr_in = do_push ? JOB_PTR_BITS'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? JOB_PTR_BITS'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = JOB_CNT_BITS'(count_ff + 1'b1);
      end else if (do_pop && !do_push) begin
         count_in = JOB_CNT_BITS'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- rtl/cfm_back.sv -----
// ----------------------------------------------------------------------------
// Crossing frequency meter back end
// Rounded division by a bit-serial divider, decimal digit split and result
// sequencing into a one-word output register.
// ----------------------------------------------------------------------------
module cfm_back
   import cfm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  job_empty,
   input  job_type               job,
   output logic                  job_pop,
   input  logic                  rsp_pop,
   output logic                  rsp_empty,
   output logic [KIND_BITS-1:0]  rsp_kind,
   output logic [SEG_BITS-1:0]   rsp_segments,
   output logic [FREQ_BITS-1:0]  rsp_frequency,
   output logic                  rsp_last
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SETUP  = 3'd1;
   localparam logic [2:0] ST_DIVIDE = 3'd2;
   localparam logic [2:0] ST_CLAMP  = 3'd3;
   localparam logic [2:0] ST_DIGITS = 3'd4;
   localparam logic [2:0] ST_EMIT   = 3'd5;
   localparam logic [2:0] ST_BLANK  = 3'd6;
   localparam logic [2:0] ST_REPORT = 3'd7;

   logic [2:0]                state_ff, state_in;
   job_type                   job_ff, job_in;
   logic [DVD_BITS-1:0]       rem_ff, rem_in;
   logic [QUO_BITS-1:0]       dq_ff, dq_in;
   logic [STEP_BITS-1:0]      step_ff, step_in;
   logic [FREQ_BITS-1:0]      freq_ff, freq_in;
   logic [FREQ_BITS-1:0]      work_ff, work_in;
   logic [DIGIT_CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [DIGIT_IDX_BITS-1:0] idx_ff, idx_in;
   logic [DIGIT_BITS-1:0]     digit_ff [MAX_DIGITS];
   logic                      digit_we;

   logic                      out_valid_ff, out_valid_in;
   logic [KIND_BITS-1:0]      out_kind_ff, out_kind_in;
   logic [SEG_BITS-1:0]       out_seg_ff, out_seg_in;
   logic [FREQ_BITS-1:0]      out_freq_ff;
   logic                      out_last_ff, out_last_in;
   logic                      out_load;
   logic                      slot_free;

   logic [PROD_BITS-1:0]      product;
   logic [DVD_BITS-1:0]       dividend;
   logic [DVD_BITS-1:0]       divisor;
   logic [DVD_BITS:0]         trial;
   logic [DVD_BITS:0]         diff;
   logic                      fits;

   logic [2*FREQ_BITS-1:0]    recip_prod;
   logic [FREQ_BITS-1:0]      quot10;
   logic [FREQ_BITS-1:0]      tenfold;
   logic [FREQ_BITS-1:0]      rem10;

   // Rounded quotient floor((2*num + e) / (2*e)) fits in QUO_BITS, so the
   // head of the dividend above those bits is already below the divisor.
   assign product  = PROD_BITS'(job_ff.periods) * PROD_BITS'(US_PER_S);
   assign dividend = DVD_BITS'({product, 1'b0}) + DVD_BITS'(job_ff.elapsed);
   assign divisor  = {job_ff.elapsed, 1'b0};
   assign trial    = {rem_ff, dq_ff[QUO_BITS-1]};
   assign fits     = (trial >= {1'b0, divisor});
   assign diff     = trial - {1'b0, divisor};

   assign recip_prod = (2*FREQ_BITS)'(work_ff) * (2*FREQ_BITS)'(RECIP_TEN);
   assign quot10     = FREQ_BITS'(recip_prod >> RECIP_SHIFT);
   assign tenfold    = FREQ_BITS'({quot10, 3'b000}) + FREQ_BITS'({quot10, 1'b0});
   assign rem10      = work_ff - tenfold;

   assign slot_free  = !out_valid_ff || rsp_pop;

   always_comb begin
      state_in    = state_ff;
      job_in      = job_ff;
      rem_in      = rem_ff;
      dq_in       = dq_ff;
      step_in     = step_ff;
      freq_in     = freq_ff;
      work_in     = work_ff;
      cnt_in      = cnt_ff;
      idx_in      = idx_ff;
      digit_we    = 1'b0;
      job_pop     = 1'b0;
      out_load    = 1'b0;
      out_kind_in = KIND_BLANK;
      out_seg_in  = '0;
      out_last_in = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (!job_empty) begin
               job_pop  = 1'b1;
               job_in   = job;
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            step_in = '0;
            if (job_ff.elapsed == '0) begin
               dq_in    = QUO_BITS'(FREQ_CAP);
               state_in = ST_CLAMP;
            end else begin
               rem_in   = DVD_BITS'(dividend[DVD_BITS-1:QUO_BITS]);
               dq_in    = dividend[QUO_BITS-1:0];
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            rem_in  = fits ? diff[DVD_BITS-1:0] : trial[DVD_BITS-1:0];
            dq_in   = {dq_ff[QUO_BITS-2:0], fits};
            step_in = STEP_BITS'(step_ff + 1'b1);
            if (step_ff == STEP_BITS'(QUO_BITS - 1)) begin
               state_in = ST_CLAMP;
            end
         end
         ST_CLAMP: begin
            freq_in  = (dq_ff > QUO_BITS'(FREQ_CAP)) ? FREQ_CAP : dq_ff[FREQ_BITS-1:0];
            work_in  = freq_in;
            cnt_in   = '0;
            state_in = job_ff.mode ? ST_REPORT : ST_DIGITS;
         end
         ST_DIGITS: begin
            if (work_ff == '0) begin
               idx_in   = DIGIT_IDX_BITS'(cnt_ff - 1'b1);
               state_in = (cnt_ff == '0) ? ST_BLANK : ST_EMIT;
            end else begin
               digit_we = 1'b1;
               work_in  = quot10;
               cnt_in   = DIGIT_CNT_BITS'(cnt_ff + 1'b1);
            end
         end
         ST_EMIT: begin
            if (slot_free) begin
               out_load    = 1'b1;
               out_kind_in = KIND_DIGIT;
               out_seg_in  = seg_decode(digit_ff[idx_ff]) |
                             ((idx_ff == '0) ? SEG_DOT : SEG_BITS'(0));
               if (idx_ff == '0) begin
                  state_in = ST_BLANK;
               end else begin
                  idx_in = DIGIT_IDX_BITS'(idx_ff - 1'b1);
               end
            end
         end
         ST_BLANK: begin
            if (slot_free) begin
               out_load    = 1'b1;
               out_kind_in = KIND_BLANK;
               out_last_in = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         ST_REPORT: begin
            if (slot_free) begin
               out_load    = 1'b1;
               out_kind_in = KIND_REPORT;
               out_last_in = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      out_valid_in = out_load ? 1'b1 : (rsp_pop ? 1'b0 : out_valid_ff);
   end

   always_ff @(posedge clock) begin
      job_ff  <= job_in;
      rem_ff  <= rem_in;
      dq_ff   <= dq_in;
      step_ff <= step_in;
      freq_ff <= freq_in;
      work_ff <= work_in;
      cnt_ff  <= cnt_in;
      idx_ff  <= idx_in;
      if (digit_we) begin
         digit_ff[cnt_ff[DIGIT_IDX_BITS-1:0]] <= rem10[DIGIT_BITS-1:0];
      end
      if (out_load) begin
         out_kind_ff <= out_kind_in;
         out_seg_ff  <= out_seg_in;
         out_freq_ff <= freq_ff;
         out_last_ff <= out_last_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_empty     = !out_valid_ff;
   assign rsp_kind      = out_kind_ff;
   assign rsp_segments  = out_seg_ff;
   assign rsp_frequency = out_freq_ff;
   assign rsp_last      = out_last_ff;

   // The partial remainder always stays below the divisor.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIVIDE |-> rem_ff < divisor)
      else $error("divider remainder reached the divisor");

   // Digit readout never points past the digits that were split off.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT |-> DIGIT_CNT_BITS'(idx_ff) < cnt_ff)
      else $error("digit index beyond digit count");

   // The final word of a measurement returns the sequencer to idle.
   assert property (@(posedge clock) disable iff (reset)
      out_load && out_last_in |=> state_ff == ST_IDLE)
      else $error("sequencer busy after final word");

endmodule

// ----- rtl/crossing_frequency_meter_ssd_top.sv -----
// ----------------------------------------------------------------------------
// Crossing frequency meter with seven-segment readout
// Measures the frequency of an ADC signal from threshold crossings and
// reports it as seven-segment digit words or as a plain frequency word.
// ----------------------------------------------------------------------------
// Usage: each input word is one ADC sample with its microsecond timestamp and
// the mode switch level, pushed on the req_ queue port (push/full). Result
// words leave on the rsp_ queue port (empty/pop); the oldest word sits on the
// ports while empty is low. The csr_ port holds the threshold at byte address
// 0 and the crossings per measurement at byte address 4.
// A sample that does not finish a measurement produces no word and is taken
// whenever the job queue has room. A finishing sample becomes a job in a
// two-entry queue; the back end then fetches it, forms the dividend, runs the
// bit-serial divider (one quotient bit per cycle) and clamps the result. In
// report mode the single word is then loaded once the output register is
// free. In digit mode the value is split at one digit per cycle until it
// reaches zero, then one word per digit and a blank follow. Zero elapsed time
// skips the divider. The back end takes the next job only after the final
// word of the current one is loaded.
// Reset clears the crossing state, the queues and the sequencer and loads
// the register defaults. When the receiver stalls, the output word holds,
// the back end waits, and full rises once two finished measurements queue up.
module crossing_frequency_meter_ssd_top
   import cfm_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_push,
   output logic                     req_full,
   input  logic [SAMPLE_BITS-1:0]   req_sample,
   input  logic [TIME_BITS-1:0]     req_now_us,
   input  logic                     req_mode_switch,
   output logic                     rsp_empty,
   input  logic                     rsp_pop,
   output logic [KIND_BITS-1:0]     rsp_kind,
   output logic [SEG_BITS-1:0]      rsp_segments,
   output logic [FREQ_BITS-1:0]     rsp_frequency,
   output logic                     rsp_last,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready
);

   logic [SAMPLE_BITS-1:0] threshold_ff, threshold_in;
   logic [COUNT_BITS-1:0]  crossings_ff, crossings_in;
   logic                   csr_write;
   logic                   item_accept;
   logic                   job_push;
   job_type                push_job;
   logic                   job_pop;
   job_type                pop_job;
   logic                   job_empty;

   // Register file. The port never waits, and bit 2 of the address selects
   // the register, so the remaining address bits alias.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      threshold_in = threshold_ff;
      crossings_in = crossings_ff;
      unique case (csr_paddr[2])
         CSR_THRESHOLD: begin
            if (csr_write) begin
               threshold_in = csr_pwdata[SAMPLE_BITS-1:0];
            end
            csr_prdata = CSR_DATA_BITS'(threshold_ff);
         end
         CSR_CROSSINGS: begin
            if (csr_write) begin
               crossings_in = csr_pwdata[COUNT_BITS-1:0];
            end
            csr_prdata = CSR_DATA_BITS'(crossings_ff);
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESHOLD_RESET;
         crossings_ff <= CROSSINGS_RESET;
      end else begin
         threshold_ff <= threshold_in;
         crossings_ff <= crossings_in;
      end
   end

   // A sample is taken whenever the job queue has room; samples that finish
   // no measurement pass straight through the front end.
   assign item_accept = req_push && !req_full;

   cfm_front u_front (
      .clock       (clock),
      .reset       (reset),
      .threshold   (threshold_ff),
      .crossings   (crossings_ff),
      .item_accept (item_accept),
      .sample      (req_sample),
      .now_us      (req_now_us),
      .mode_switch (req_mode_switch),
      .job_push    (job_push),
      .job         (push_job)
   );

   cfm_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (job_push),
      .push_job (push_job),
      .full     (req_full),
      .pop      (job_pop),
      .pop_job  (pop_job),
      .empty    (job_empty)
   );

   cfm_back u_back (
      .clock         (clock),
      .reset         (reset),
      .job_empty     (job_empty),
      .job           (pop_job),
      .job_pop       (job_pop),
      .rsp_pop       (rsp_pop),
      .rsp_empty     (rsp_empty),
      .rsp_kind      (rsp_kind),
      .rsp_segments  (rsp_segments),
      .rsp_frequency (rsp_frequency),
      .rsp_last      (rsp_last)
   );

endmodule
